### sv/filament_buck_ramp_sequencer_core_macros.svh
// assertion macros shared by the filament buck sequencer rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef FILAMENT_BUCK_RAMP_SEQUENCER_CORE_MACROS_SVH
`define FILAMENT_BUCK_RAMP_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FBRS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fbrs assertion failed");

// next-cycle implication, disabled during reset
`define FBRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fbrs assertion failed");

`endif

### sv/fbrs_pkg.sv
// types, codes and ramp helpers for the filament buck ramp sequencer
// no dependencies; used by fbrs_chan_update and the top level
package fbrs_pkg;

  localparam int CHANNELS = 2;
  localparam int DUTY_W   = 16;
  localparam int CFG_IDX_W = 3;

  // operation codes
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_SET_TGT  = 2'd1;
  localparam logic [1:0] FUNC_BUCK_ON  = 2'd2;
  localparam logic [1:0] FUNC_BUCK_OFF = 2'd3;

  // lamp state codes
  localparam logic [1:0] MODE_INIT      = 2'd0;
  localparam logic [1:0] MODE_PREPARE   = 2'd1;
  localparam logic [1:0] MODE_TRANSIENT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_INIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MIN = 3'd4;

  localparam logic [DUTY_W-1:0] RST_DUTY_MIN   = 16'd0;
  localparam logic [DUTY_W-1:0] RST_DUTY_INIT  = 16'd16384;
  localparam logic [DUTY_W-1:0] RST_DUTY_STEP  = 16'd64;
  localparam logic [DUTY_W-1:0] RST_TARGET_MAX = 16'd65535;
  localparam logic [DUTY_W-1:0] RST_TARGET_MIN = 16'd0;

  localparam logic [2:0] SETTLE_TICKS = 3'd5;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_min;
    logic [DUTY_W-1:0] duty_init;
    logic [DUTY_W-1:0] duty_step;
    logic [DUTY_W-1:0] target_max;
    logic [DUTY_W-1:0] target_min;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [DUTY_W-1:0] duty;
    logic [DUTY_W-1:0] target;
    logic              on_req;
    logic              run;
    logic              steady;
    logic [2:0]        settle;
  } chan_state_t;

  function automatic logic [DUTY_W-1:0] sat_add(input logic [DUTY_W-1:0] a,
                                                input logic [DUTY_W-1:0] b);
    logic [DUTY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DUTY_W] ? {DUTY_W{1'b1}} : s[DUTY_W-1:0];
  endfunction

  function automatic logic [DUTY_W-1:0] sat_sub(input logic [DUTY_W-1:0] a,
                                                input logic [DUTY_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  // raise by one step if below, then lower by one step if above
  function automatic logic [DUTY_W-1:0] ramp_toward(input logic [DUTY_W-1:0] d,
                                                    input logic [DUTY_W-1:0] level,
                                                    input logic [DUTY_W-1:0] step);
    logic [DUTY_W-1:0] up;
    up = (d < level) ? sat_add(d, step) : d;
    return (up > level) ? sat_sub(up, step) : up;
  endfunction

endpackage

### sv/fbrs_chan_update.sv
// next-state logic of one sequencer channel for one operation
// depends on fbrs_pkg
module fbrs_chan_update (
  input  logic [1:0]          func_i,
  input  logic                channel_i,
  input  logic [15:0]         target_value_i,
  input  logic                hv_active_i,
  input  fbrs_pkg::cfg_t      cfg_i,
  input  fbrs_pkg::chan_state_t cur_i,
  output fbrs_pkg::chan_state_t nxt_o,
  output logic                slope_o
);
  import fbrs_pkg::*;

  logic [DUTY_W-1:0] down_duty;
  logic [DUTY_W-1:0] prep_duty;
  logic [DUTY_W-1:0] track_duty;
  logic [DUTY_W-1:0] clamp_hi;
  logic [DUTY_W-1:0] clamped_tgt;

  assign down_duty  = sat_sub(cur_i.duty, cfg_i.duty_step);
  assign prep_duty  = ramp_toward(cur_i.duty, cfg_i.duty_init, cfg_i.duty_step);
  assign track_duty = ramp_toward(cur_i.duty, cur_i.target, cfg_i.duty_step);

  // upper clamp first, lower clamp wins when the limits cross
  assign clamp_hi    = (target_value_i > cfg_i.target_max) ? cfg_i.target_max
                                                           : target_value_i;
  assign clamped_tgt = (clamp_hi < cfg_i.target_min) ? cfg_i.target_min : clamp_hi;

  always_comb begin
    nxt_o   = cur_i;
    slope_o = 1'b0;
    case (func_i)
      FUNC_TICK: begin
        case (cur_i.mode)
          MODE_INIT: begin
            if (cur_i.duty > cfg_i.duty_min) begin
              nxt_o.duty = (down_duty < cfg_i.duty_min) ? cfg_i.duty_min : down_duty;
            end else if (cur_i.on_req) begin
              nxt_o.mode   = MODE_PREPARE;
              nxt_o.settle = '0;
              nxt_o.steady = 1'b0;
            end
          end
          MODE_PREPARE: begin
            if (!cur_i.on_req) begin
              nxt_o.mode = MODE_INIT;
            end else begin
              if (channel_i == 1'b0) begin
                slope_o = 1'b1;
              end else begin
                nxt_o.duty = prep_duty;
              end
              if (cur_i.settle < SETTLE_TICKS) begin
                nxt_o.settle = cur_i.settle + 3'd1;
              end else begin
                nxt_o.settle = SETTLE_TICKS;
                nxt_o.steady = 1'b1;
                if (hv_active_i) begin
                  nxt_o.settle = '0;
                  nxt_o.mode   = MODE_TRANSIENT;
                end
              end
            end
          end
          MODE_TRANSIENT: begin
            if (!cur_i.on_req) begin
              nxt_o.mode = MODE_INIT;
            end else if (channel_i == 1'b1) begin
              nxt_o.duty = track_duty;
            end
          end
          default: begin
            nxt_o.mode = MODE_INIT;
          end
        endcase
      end
      FUNC_SET_TGT: begin
        nxt_o.target = clamped_tgt;
      end
      FUNC_BUCK_ON: begin
        if (cur_i.mode == MODE_INIT) begin
          nxt_o.on_req = 1'b1;
          nxt_o.run    = 1'b1;
        end
      end
      default: begin
        nxt_o.mode   = MODE_INIT;
        nxt_o.on_req = 1'b0;
        nxt_o.run    = 1'b0;
      end
    endcase
  end

endmodule

### sv/filament_buck_ramp_sequencer_core.sv
// an accepted item passes through the input register and then the result register
// throughput: one item per cycle while the output is not stalled; the channel state updates
// as the result register loads, so an item right behind reads the state its predecessor left
// reset: all channel state cleared to init, config registers to their reset values
// depends on fbrs_pkg, fbrs_chan_update and the macros header
module filament_buck_ramp_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic        channel_i,
  input  logic [15:0] target_value_i,
  input  logic        hv_active_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_channel_o,
  output logic [1:0]  lamp_state_o,
  output logic [15:0] duty_o,
  output logic        steady_o,
  output logic        buck_enabled_o,
  output logic        ref_slope_request_o
);
  import fbrs_pkg::*;
  `include "filament_buck_ramp_sequencer_core_macros.svh"

  cfg_t        cfg_q;
  chan_state_t chan_q [CHANNELS];
  chan_state_t cur_state;
  chan_state_t nxt_state;
  logic        slope;

  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_func_q;
  logic        s1_ch_q;
  logic [15:0] s1_tv_q;
  logic        s1_hv_q;

  logic        out_valid_q, out_valid_d;
  logic        res_ch_q;
  logic [1:0]  res_mode_q;
  logic [15:0] res_duty_q;
  logic        res_steady_q;
  logic        res_run_q;
  logic        res_slope_q;

  logic        in_xfer;
  logic        fire;
  logic        in_range;

  assign fire       = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | fire;
  assign in_xfer    = in_valid_i & in_ready_o;
  assign in_range   = int'(s1_ch_q) < CHANNELS;

  assign s1_valid_d  = in_xfer ? 1'b1 : (fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  assign cur_state = chan_q[s1_ch_q];

  fbrs_chan_update u_update (
    .func_i         (s1_func_q),
    .channel_i      (s1_ch_q),
    .target_value_i (s1_tv_q),
    .hv_active_i    (s1_hv_q),
    .cfg_i          (cfg_q),
    .cur_i          (cur_state),
    .nxt_o          (nxt_state),
    .slope_o        (slope)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_min   <= RST_DUTY_MIN;
      cfg_q.duty_init  <= RST_DUTY_INIT;
      cfg_q.duty_step  <= RST_DUTY_STEP;
      cfg_q.target_max <= RST_TARGET_MAX;
      cfg_q.target_min <= RST_TARGET_MIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DUTY_MIN:   cfg_q.duty_min   <= cfg_wdata_i;
        CFG_DUTY_INIT:  cfg_q.duty_init  <= cfg_wdata_i;
        CFG_DUTY_STEP:  cfg_q.duty_step  <= cfg_wdata_i;
        CFG_TARGET_MAX: cfg_q.target_max <= cfg_wdata_i;
        CFG_TARGET_MIN: cfg_q.target_min <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_q[i] <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (fire && in_range) begin
        chan_q[s1_ch_q] <= nxt_state;
      end
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_func_q <= func_i;
      s1_ch_q   <= channel_i;
      s1_tv_q   <= target_value_i;
      s1_hv_q   <= hv_active_i;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_ch_q     <= s1_ch_q;
      res_mode_q   <= in_range ? nxt_state.mode   : 2'd0;
      res_duty_q   <= in_range ? nxt_state.duty   : 16'd0;
      res_steady_q <= in_range & nxt_state.steady;
      res_run_q    <= in_range & nxt_state.run;
      res_slope_q  <= in_range & slope;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_channel_o       = res_ch_q;
  assign lamp_state_o        = res_mode_q;
  assign duty_o              = res_duty_q;
  assign steady_o            = res_steady_q;
  assign buck_enabled_o      = res_run_q;
  assign ref_slope_request_o = res_slope_q;

  `FBRS_ASSERT_IMPL(a_stall_holds_item, clk_i, rst_ni, !in_ready_o, s1_valid_q)
  `FBRS_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, fire, out_valid_q)
  `FBRS_ASSERT_IMPL(a_transient_is_steady, clk_i, rst_ni,
                    out_valid_q && (res_mode_q == MODE_TRANSIENT), res_steady_q)
  `FBRS_ASSERT_IMPL(a_slope_only_ch0, clk_i, rst_ni, out_valid_q && res_slope_q,
                    (res_ch_q == 1'b0) && (res_mode_q != MODE_INIT))

endmodule
